// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the coincidence window design files (used by cfcw_engine).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define CFCW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define CFCW_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CFCW_ASSERT(lbl, clk, rst, prop)
`define CFCW_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ----- design/cfcw_pkg.sv -----
// ----------------------------------------------------------------------------
// cfcw_pkg
// Types and constants of the four channel coincidence window core.
// ----------------------------------------------------------------------------
package cfcw_pkg;

  // sizes
  localparam int NREF         = 3;
  localparam int CH_W         = 2;
  localparam int TIME_W       = 32;
  localparam int HEIGHT_W     = 16;
  localparam int WIN_W        = 16;
  localparam int IDX_W        = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int MAX_PEAKS_DEF = 1024;
  localparam int CMD_DEPTH    = 4;
  localparam int RES_DEPTH    = 2;

  // register reset values
  localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST   = 16'd20;
  localparam logic [TIME_W-1:0] BACKGROUND_LOW_RST  = 32'd10000000;
  localparam logic [TIME_W-1:0] BACKGROUND_HIGH_RST = 32'd64000000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BACKGROUND_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_BACKGROUND_HIGH = 2'd2;

  // opcodes of an input word
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WIN_W-1:0]  window_length;
    logic [TIME_W-1:0] background_low;
    logic [TIME_W-1:0] background_high;
  } cfg_t;

  typedef struct packed {
    opcode_t                    op;
    logic [CH_W-1:0]            ch;
    logic [TIME_W-1:0]          peak_time;
    logic signed [HEIGHT_W-1:0] peak_height;
  } cmd_t;

  typedef struct packed {
    logic                       hit_ref0;
    logic                       hit_ref1;
    logic                       hit_ref2;
    logic                       coincident;
    logic                       in_background_window;
    logic signed [HEIGHT_W-1:0] height_out;
    logic                       overflow;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

// ----- design/cfcw_fifo.sv -----
// ----------------------------------------------------------------------------
// cfcw_fifo
// Small register queue between the front end, the engine and the result port.
// ----------------------------------------------------------------------------
module cfcw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- design/cfcw_front.sv -----
// ----------------------------------------------------------------------------
// cfcw_front
// Input decode: drops words that have no effect and queues the rest.
// ----------------------------------------------------------------------------
module cfcw_front (
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           opcode,
  input  logic [cfcw_pkg::CH_W-1:0]            ref_channel,
  input  logic [cfcw_pkg::TIME_W-1:0]          peak_time,
  input  logic signed [cfcw_pkg::HEIGHT_W-1:0] peak_height,
  input  logic                                 cmd_full,
  output logic                                 cmd_push,
  output cfcw_pkg::cmd_t                       cmd
);

  logic accept;
  logic useful;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // classify: unused opcode and loads to a missing channel do nothing
  always_comb begin
    case (opcode)
      cfcw_pkg::OP_CLEAR: useful = 1'b1;
      cfcw_pkg::OP_LOAD:  useful = (ref_channel < cfcw_pkg::CH_W'(cfcw_pkg::NREF));
      cfcw_pkg::OP_QUERY: useful = 1'b1;
      default:            useful = 1'b0;
    endcase
  end

  assign cmd_push        = accept && useful;
  assign cmd.op          = cfcw_pkg::opcode_t'(opcode);
  assign cmd.ch          = ref_channel;
  assign cmd.peak_time   = peak_time;
  assign cmd.peak_height = peak_height;

endmodule

// ----- design/cfcw_engine.sv -----
// ----------------------------------------------------------------------------
// cfcw_engine
// Back end: per-channel peak stores, load/clear handling and the query scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfcw_engine #(
  parameter int MAX_PEAKS = cfcw_pkg::MAX_PEAKS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cfcw_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  cfcw_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           out_full,
  output logic           out_push,
  output cfcw_pkg::res_t res
);

  localparam int AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int CW = $clog2(MAX_PEAKS + 1);
  localparam int NR = cfcw_pkg::NREF;

  cfcw_pkg::state_t state;
  cfcw_pkg::state_t state_next;

  logic [AW-1:0]                  addr;
  logic [AW-1:0]                  scan_last;
  logic [cfcw_pkg::TIME_W-1:0]    q_time;
  logic signed [cfcw_pkg::HEIGHT_W-1:0] q_height;
  logic                           ovf;
  logic                           rd_valid;

  logic          take;
  logic          clr_en;
  logic          load_en;
  logic          q_start;
  logic [CW-1:0] cnt [NR];
  logic [NR-1:0] hit_vec;
  logic [NR-1:0] drop_vec;
  logic [CW-1:0] max01;
  logic [CW-1:0] nmax;
  logic          coin;

  assign take    = (state == cfcw_pkg::ST_IDLE) && !cmd_empty;
  assign clr_en  = take && (cmd.op == cfcw_pkg::OP_CLEAR);
  assign load_en = take && (cmd.op == cfcw_pkg::OP_LOAD);
  assign q_start = take && (cmd.op == cfcw_pkg::OP_QUERY);

  // longest store sets the scan length
  assign max01 = (cnt[0] > cnt[1]) ? cnt[0] : cnt[1];
  assign nmax  = (max01 > cnt[2]) ? max01 : cnt[2];

  // one lane per reference channel: store, count, read and match
  for (genvar k = 0; k < NR; k++) begin : g_lane
    logic [cfcw_pkg::TIME_W-1:0] mem [MAX_PEAKS];
    logic [cfcw_pkg::TIME_W-1:0] rd;
    logic [CW-1:0]               count;
    logic                        sel;
    logic                        lfull;
    logic                        ok;
    logic                        hit;
    logic [cfcw_pkg::TIME_W-1:0] diff;

    assign sel         = (cmd.ch == cfcw_pkg::CH_W'(k));
    assign lfull       = (count == CW'(MAX_PEAKS));
    assign diff        = q_time - rd;
    assign cnt[k]      = count;
    assign hit_vec[k]  = hit;
    assign drop_vec[k] = load_en && sel && lfull;

    // peak store
    always_ff @(posedge clk) begin
      if (load_en && sel && !lfull) begin
        mem[count[AW-1:0]] <= cmd.peak_time;
      end
      rd <= mem[addr];
      ok <= (CW'(addr) < count);
    end

    // fill count
    always_ff @(posedge clk) begin
      if (rst) begin
        count <= '0;
      end else if (clr_en) begin
        count <= '0;
      end else if (load_en && sel && !lfull) begin
        count <= count + 1'b1;
      end
    end

    // hit accumulator, cleared at query start
    always_ff @(posedge clk) begin
      if (q_start) begin
        hit <= 1'b0;
      end else if (rd_valid && ok && (rd <= q_time) &&
                   (diff < {{(cfcw_pkg::TIME_W-cfcw_pkg::WIN_W){1'b0}},
                            cfg.window_length})) begin
        hit <= 1'b1;
      end
    end
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cfcw_pkg::ST_IDLE;
      ovf      <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == cfcw_pkg::ST_SCAN);
      if (clr_en) begin
        ovf <= 1'b0;
      end else if (|drop_vec) begin
        ovf <= 1'b1;
      end
    end
  end

  // scan address and query payload
  always_ff @(posedge clk) begin
    if (q_start) begin
      addr      <= '0;
      scan_last <= AW'(nmax - 1'b1);
      q_time    <= cmd.peak_time;
      q_height  <= cmd.peak_height;
    end else if (state == cfcw_pkg::ST_SCAN) begin
      addr <= addr + 1'b1;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    case (state)
      cfcw_pkg::ST_IDLE: begin
        cmd_pop = !cmd_empty;
        if (q_start) begin
          state_next = (nmax == '0) ? cfcw_pkg::ST_DONE : cfcw_pkg::ST_SCAN;
        end
      end
      cfcw_pkg::ST_SCAN: begin
        if (addr == scan_last) begin
          state_next = cfcw_pkg::ST_DRAIN;
        end
      end
      cfcw_pkg::ST_DRAIN: begin
        state_next = cfcw_pkg::ST_DONE;
      end
      cfcw_pkg::ST_DONE: begin
        out_push = !out_full;
        if (!out_full) begin
          state_next = cfcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfcw_pkg::ST_IDLE;
      end
    endcase
  end

  // result word
  assign coin                     = &hit_vec;
  assign res.hit_ref0             = hit_vec[0];
  assign res.hit_ref1             = hit_vec[1];
  assign res.hit_ref2             = hit_vec[2];
  assign res.coincident           = coin;
  assign res.in_background_window = coin && (q_time > cfg.background_low) &&
                                    (q_time < cfg.background_high);
  assign res.height_out           = q_height;
  assign res.overflow             = ovf;

  // checks
  `CFCW_ASSERT(a_count_bound, clk, rst, (cnt[0] <= CW'(MAX_PEAKS)) && (cnt[1] <= CW'(MAX_PEAKS)) && (cnt[2] <= CW'(MAX_PEAKS)))
  `CFCW_ASSERT(a_query_start, clk, rst, q_start |=> (state != cfcw_pkg::ST_IDLE) && (hit_vec == '0))
  `CFCW_ASSERT(a_scan_addr, clk, rst, (state == cfcw_pkg::ST_SCAN) |-> (addr <= scan_last))
  `CFCW_ASSERT(a_drain_data, clk, rst, (state == cfcw_pkg::ST_DRAIN) |-> rd_valid)
  `CFCW_ASSERT(a_push_done, clk, rst, out_push |-> (state == cfcw_pkg::ST_DONE) && !out_full)

endmodule

// ----- design/four_channel_coincidence_window_core.sv -----
// ----------------------------------------------------------------------------
// four_channel_coincidence_window_core
// Stores reference peak times per event and flags fourth-channel coincidences.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// input     push / full           opcode, ref_channel, peak_time, peak_height
// result    pop / empty           hit_ref0..2, coincident, in_background_window,
//                                 height_out, overflow
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Clear and load words are done while idle. A query scans N entries of
// each store, one entry a cycle (all three stores in parallel), N being
// the largest fill count; the engine takes no command until it is done.
// Input words queue in a four-word command FIFO, so push stalls only when
// it fills; results wait in a two-word FIFO, and the engine holds a finished
// query while that is full. Synchronous reset empties all stores at once.
// ----------------------------------------------------------------------------
module four_channel_coincidence_window_core #(
  parameter int MAX_PEAKS = cfcw_pkg::MAX_PEAKS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input words
  input  logic                                   push,
  output logic                                   full,
  input  logic [1:0]                             opcode,
  input  logic [cfcw_pkg::CH_W-1:0]              ref_channel,
  input  logic [cfcw_pkg::TIME_W-1:0]            peak_time,
  input  logic signed [cfcw_pkg::HEIGHT_W-1:0]   peak_height,
  // result words
  output logic                                   empty,
  input  logic                                   pop,
  output logic                                   hit_ref0,
  output logic                                   hit_ref1,
  output logic                                   hit_ref2,
  output logic                                   coincident,
  output logic                                   in_background_window,
  output logic signed [cfcw_pkg::HEIGHT_W-1:0]   height_out,
  output logic                                   overflow,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cfcw_pkg::IDX_W-1:0]             cfg_index,
  input  logic [cfcw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  cfcw_pkg::cfg_t cfg;
  cfcw_pkg::cmd_t cmd_in;
  cfcw_pkg::cmd_t cmd_out;
  cfcw_pkg::res_t res_in;
  cfcw_pkg::res_t res_out;

  logic                       cmd_push;
  logic                       cmd_full;
  logic                       cmd_pop;
  logic                       cmd_empty;
  logic [cfcw_pkg::CMD_W-1:0] cmd_bits;
  logic                       res_push;
  logic                       res_full;
  logic [cfcw_pkg::RES_W-1:0] res_bits;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length   <= cfcw_pkg::WINDOW_LENGTH_RST;
      cfg.background_low  <= cfcw_pkg::BACKGROUND_LOW_RST;
      cfg.background_high <= cfcw_pkg::BACKGROUND_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfcw_pkg::REG_WINDOW_LENGTH:   cfg.window_length   <= cfg_data[cfcw_pkg::WIN_W-1:0];
        cfcw_pkg::REG_BACKGROUND_LOW:  cfg.background_low  <= cfg_data;
        cfcw_pkg::REG_BACKGROUND_HIGH: cfg.background_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front end
  cfcw_front u_front (
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .ref_channel (ref_channel),
    .peak_time   (peak_time),
    .peak_height (peak_height),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // command queue
  cfcw_fifo #(
    .W     (cfcw_pkg::CMD_W),
    .DEPTH (cfcw_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd_out = cfcw_pkg::cmd_t'(cmd_bits);

  // engine
  cfcw_engine #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .res       (res_in)
  );

  // result queue
  cfcw_fifo #(
    .W     (cfcw_pkg::RES_W),
    .DEPTH (cfcw_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  // result ports
  assign res_out              = cfcw_pkg::res_t'(res_bits);
  assign hit_ref0             = res_out.hit_ref0;
  assign hit_ref1             = res_out.hit_ref1;
  assign hit_ref2             = res_out.hit_ref2;
  assign coincident           = res_out.coincident;
  assign in_background_window = res_out.in_background_window;
  assign height_out           = res_out.height_out;
  assign overflow             = res_out.overflow;

endmodule

// ----- dv/four_channel_coincidence_window_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_channel_coincidence_window_checker
// Watches the input, configuration and result ports of the coincidence
// window core. It keeps its own copy of the reference stores and registers,
// works out the result word of every accepted query and compares each
// popped result word with the oldest one still waiting, field by field.
// ----------------------------------------------------------------------------
module four_channel_coincidence_window_checker
  import cfcw_pkg::*;
#(
  parameter int MAX_PEAKS = MAX_PEAKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        push,
  input  logic                        full,
  input  logic [1:0]                  opcode,
  input  logic [CH_W-1:0]             ref_channel,
  input  logic [TIME_W-1:0]           peak_time,
  input  logic signed [HEIGHT_W-1:0]  peak_height,
  // result words
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        hit_ref0,
  input  logic                        hit_ref1,
  input  logic                        hit_ref2,
  input  logic                        coincident,
  input  logic                        in_background_window,
  input  logic signed [HEIGHT_W-1:0]  height_out,
  input  logic                        overflow,
  // configuration writes
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // to the testbench top
  output int                          pending_results,
  output int                          mismatch_count
);

  // event stores and registers as the core should hold them
  logic [TIME_W-1:0] stored_times [NREF][MAX_PEAKS];
  int unsigned       fill [NREF];
  bit                lost_load;
  logic [WIN_W-1:0]  window_len;
  logic [TIME_W-1:0] bg_low;
  logic [TIME_W-1:0] bg_high;

  res_t expected_words [$];
  int   errors = 0;
  int   words_seen = 0;

  assign mismatch_count  = errors;

  // a channel hits when one kept peak lies 0 .. window_len-1 ns before t
  function automatic bit channel_hit(input int ch, input logic [TIME_W-1:0] t);
    bit found;
    found = 1'b0;
    for (int i = 0; i < fill[ch]; i++) begin
      if (stored_times[ch][i] <= t && (t - stored_times[ch][i]) < TIME_W'(window_len))
        found = 1'b1;
    end
    return found;
  endfunction

  function automatic res_t coincidence_word(input logic [TIME_W-1:0] t,
                                            input logic signed [HEIGHT_W-1:0] h);
    res_t w;
    w.hit_ref0             = channel_hit(0, t);
    w.hit_ref1             = channel_hit(1, t);
    w.hit_ref2             = channel_hit(2, t);
    w.coincident           = w.hit_ref0 & w.hit_ref1 & w.hit_ref2;
    w.in_background_window = w.coincident && t > bg_low && t < bg_high;
    w.height_out           = h;
    w.overflow             = lost_load;
    return w;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(input string detail);
    $display("%0t ns: result word %0d: %s", $time, words_seen, detail);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [HEIGHT_W-1:0] got,
                             input logic [HEIGHT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // all three channels are sampled at the clock edge, results first so that
  // a query taken in the same cycle queues behind the word being popped
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      fill       = '{default: 0};
      lost_load  = 1'b0;
      window_len = WINDOW_LENGTH_RST;
      bg_low     = BACKGROUND_LOW_RST;
      bg_high    = BACKGROUND_HIGH_RST;
      expected_words.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:   window_len = cfg_data[WIN_W-1:0];
          REG_BACKGROUND_LOW:  bg_low     = cfg_data;
          REG_BACKGROUND_HIGH: bg_high    = cfg_data;
          default: ;
        endcase
      end
      // result word
      if (pop && !empty) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("popped with no query waiting");
        end else begin
          want = expected_words.pop_front();
          check_field("hit_ref0", hit_ref0, want.hit_ref0);
          check_field("hit_ref1", hit_ref1, want.hit_ref1);
          check_field("hit_ref2", hit_ref2, want.hit_ref2);
          check_field("coincident", coincident, want.coincident);
          check_field("in_background_window", in_background_window,
                      want.in_background_window);
          check_field("height_out", height_out, want.height_out);
          check_field("overflow", overflow, want.overflow);
        end
      end
      // input word
      if (push && !full) begin
        case (opcode)
          OP_CLEAR: begin
            fill      = '{default: 0};
            lost_load = 1'b0;
          end
          OP_LOAD: begin
            // channel 3 does not exist and is dropped silently
            if (ref_channel < NREF) begin
              if (fill[ref_channel] >= MAX_PEAKS) begin
                lost_load = 1'b1;
              end else begin
                stored_times[ref_channel][fill[ref_channel]] = peak_time;
                fill[ref_channel]++;
              end
            end
          end
          OP_QUERY: expected_words.push_back(coincidence_word(peak_time, peak_height));
          default: ;
        endcase
      end
    end
    // results still owed by the core
    pending_results = expected_words.size();
  end

endmodule

// ----- dv/four_channel_coincidence_window_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_channel_coincidence_window_core_test
// Drives the coincidence window core with a short directed sequence, then
// with random events (clear, reference loads at or before a base time, queries)
// under six register settings and four pacing modes, including one event
// that runs a store past capacity. The checker beside the core does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module four_channel_coincidence_window_core_test;
  import cfcw_pkg::*;

  localparam logic [1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CH_W-1:0] CH_INVALID = 2'd3;
  // long enough for a query to scan a full store of MAX_PEAKS entries
  localparam int SETTLE_CYCLES   = 1100;
  localparam int STALL_LIMIT     = 20000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 96;

  typedef enum {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       push        = 1'b0;
  logic                       full;
  logic [1:0]                 opcode      = OP_CLEAR;
  logic [CH_W-1:0]            ref_channel = '0;
  logic [TIME_W-1:0]          peak_time   = '0;
  logic signed [HEIGHT_W-1:0] peak_height = '0;
  logic                       empty;
  logic                       pop         = 1'b0;
  logic                       hit_ref0;
  logic                       hit_ref1;
  logic                       hit_ref2;
  logic                       coincident;
  logic                       in_background_window;
  logic signed [HEIGHT_W-1:0] height_out;
  logic                       overflow;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index   = REG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0]      cfg_data    = '0;
  int                         pending_results;
  int                         mismatch_count;

  pace_t             pace        = PACE_FREE;
  int                items_done  = 0;
  int                idle_cycles = 0;
  // register values as last written, used to aim the stimulus
  logic [WIN_W-1:0]  win_now     = WINDOW_LENGTH_RST;
  logic [TIME_W-1:0] bg_lo_now   = BACKGROUND_LOW_RST;
  logic [TIME_W-1:0] bg_hi_now   = BACKGROUND_HIGH_RST;

  always #1 clk = ~clk;

  four_channel_coincidence_window_core i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .opcode               (opcode),
    .ref_channel          (ref_channel),
    .peak_time            (peak_time),
    .peak_height          (peak_height),
    .empty                (empty),
    .pop                  (pop),
    .hit_ref0             (hit_ref0),
    .hit_ref1             (hit_ref1),
    .hit_ref2             (hit_ref2),
    .coincident           (coincident),
    .in_background_window (in_background_window),
    .height_out           (height_out),
    .overflow             (overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  four_channel_coincidence_window_checker i_checker (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .opcode               (opcode),
    .ref_channel          (ref_channel),
    .peak_time            (peak_time),
    .peak_height          (peak_height),
    .empty                (empty),
    .pop                  (pop),
    .hit_ref0             (hit_ref0),
    .hit_ref1             (hit_ref1),
    .hit_ref2             (hit_ref2),
    .coincident           (coincident),
    .in_background_window (in_background_window),
    .height_out           (height_out),
    .overflow             (overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .pending_results      (pending_results),
    .mismatch_count       (mismatch_count)
  );

  // percentage of cycles in which one side holds back
  function automatic int unsigned pace_pct(input pace_t p, input bit sender_side);
    case (p)
      PACE_BOTH:           return 9;
      PACE_SENDER_IDLE:    return sender_side ? 84 : 0;
      PACE_RECEIVER_STALL: return sender_side ? 0 : 84;
      default:             return 0;
    endcase
  endfunction

  // base time of an event: inside the background bounds, near either end
  // of the time range, or anywhere
  function automatic logic [TIME_W-1:0] pick_base();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4 && bg_hi_now > bg_lo_now && bg_hi_now - bg_lo_now >= 2)
      return bg_lo_now + 1 + ($urandom % (bg_hi_now - bg_lo_now - 1));
    else if (sel < 6)
      return $urandom_range(300);
    else if (sel < 8)
      return 32'hFFFF_FFFF - $urandom_range(300);
    return $urandom;
  endfunction

  // result side
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pace_pct(pace, 1'b0));
  end

  // watchdog: cycles in which no word moved on any channel
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // push stays high after acceptance; the next call either keeps it or idles
  task automatic send_word(input logic [1:0] op, input logic [CH_W-1:0] ch,
                           input logic [TIME_W-1:0] t,
                           input logic signed [HEIGHT_W-1:0] h);
    while ($urandom_range(99) < pace_pct(pace, 1'b1)) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    opcode      <= op;
    ref_channel <= ch;
    peak_time   <= t;
    peak_height <= h;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op != OP_UNUSED && !(op == OP_LOAD && ch == CH_INVALID))
      items_done++;
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0]     base;
    logic [TIME_W-1:0]     t;
    logic [CH_W-1:0]       ch;
    logic [CFG_DATA_W-1:0] win_word;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int                    target;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset registers: window 20, background 10e6 .. 64e6
    send_word(OP_QUERY, 2'd0, 32'd5, 16'sh8000);          // empty stores
    send_word(OP_LOAD, 2'd0, 32'd100, 16'sd1);
    send_word(OP_LOAD, 2'd1, 32'd110, 16'sd2);
    send_word(OP_LOAD, 2'd2, 32'd119, 16'sd3);
    send_word(OP_QUERY, 2'd0, 32'd119, 16'sh7FFF);        // all hit, ref at query time
    send_word(OP_QUERY, 2'd0, 32'd120, 16'sd1);           // channel 0 at window edge
    send_word(OP_QUERY, 2'd0, 32'd99, 16'shFFFF);         // every reference later
    send_word(OP_LOAD, CH_INVALID, 32'd120, 16'sd0);      // no such channel
    send_word(OP_UNUSED, 2'd2, 32'd119, 16'sd0);          // unused opcode
    send_word(OP_QUERY, 2'd0, 32'd139, 16'sh1234);
    send_word(OP_CLEAR, 2'd0, 32'd0, 16'sd0);
    send_word(OP_LOAD, 2'd0, 32'hFFFF_FFFF, 16'sd0);
    send_word(OP_LOAD, 2'd1, 32'd0, 16'sd0);
    send_word(OP_QUERY, 2'd0, 32'd0, 16'sd0);             // no wrap of the difference
    send_word(OP_QUERY, 2'd0, 32'hFFFF_FFFF, 16'sh8001);
    send_word(OP_CLEAR, 2'd0, 32'd0, 16'sd0);
    send_word(OP_LOAD, 2'd0, 32'd20000000, 16'sd0);
    send_word(OP_LOAD, 2'd1, 32'd19999981, 16'sd0);
    send_word(OP_LOAD, 2'd2, 32'd19999999, 16'sd0);
    send_word(OP_QUERY, 2'd0, 32'd20000000, 16'sh5555);   // inside background bounds
    send_word(OP_QUERY, 2'd0, 32'd20000019, 16'shAAAA);
    send_word(OP_CLEAR, 2'd0, 32'd0, 16'sd0);
    send_word(OP_QUERY, 2'd0, 32'd20000000, 16'sd7);      // cleared event

    for (int phase = 0; phase < PHASES; phase++) begin
      // let the core go quiet, then reprogram
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: begin
          win_word = 32'h0000_FFFF;
          lo       = 32'h0;
          hi       = 32'hFFFF_FFFF;
        end
        1: begin
          win_word = 32'h0;                                // zero window
          lo       = 32'd5;
          hi       = 32'd5;                                // empty bounds
        end
        2: begin
          win_word = 32'd1;
          lo       = 32'hFFFF_FFFF;                        // inverted bounds
          hi       = 32'h0;
        end
        4: begin
          win_word = {16'hABCD, WINDOW_LENGTH_RST};        // upper bits are ignored
          lo       = BACKGROUND_LOW_RST;
          hi       = BACKGROUND_HIGH_RST;
        end
        default: begin
          win_word = {16'($urandom), 16'($urandom_range(1, 400))};
          lo       = $urandom_range(32'h7FFF_FFFF);
          hi       = lo + $urandom_range(32'h7FFF_FFFF);
        end
      endcase
      write_reg(REG_WINDOW_LENGTH, win_word);
      write_reg(REG_BACKGROUND_LOW, lo);
      write_reg(REG_BACKGROUND_HIGH, hi);
      cfg_valid <= 1'b0;
      win_now   = win_word[WIN_W-1:0];
      bg_lo_now = lo;
      bg_hi_now = hi;
      pace      = pace_t'(phase % 4);

      // random events: mostly clear, loads at or before a base time, queries
      target = items_done + ITEMS_PER_PHASE;
      while (items_done < target) begin
        base = pick_base();
        if ($urandom_range(9) != 0)
          send_word(OP_CLEAR, CH_W'($urandom), $urandom, HEIGHT_W'($urandom));
        repeat ($urandom_range(10)) begin
          ch = ($urandom_range(19) == 0) ? CH_INVALID : CH_W'($urandom_range(NREF - 1));
          send_word(OP_LOAD, ch, base - $urandom_range(win_now + 2), HEIGHT_W'($urandom));
        end
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(5))
            0:       t = $urandom;
            1:       t = base - $urandom_range(1, 3);
            2:       t = base + win_now;
            default: t = base + $urandom_range(2);
          endcase
          send_word(OP_QUERY, CH_W'($urandom), t, HEIGHT_W'($urandom));
        end
        if ($urandom_range(19) == 0)
          send_word(OP_UNUSED, CH_W'($urandom), $urandom, HEIGHT_W'($urandom));
        // now and then hold off until every result is out
        if ($urandom_range(39) == 0)
          wait_for_results();
      end

      // one store run past capacity; at the base time only its last kept entry can hit
      if (phase == 0) begin
        base = 32'h4000_0000 + $urandom_range(32'h3FFF_FFFF);
        ch   = CH_W'($urandom_range(NREF - 1));
        send_word(OP_CLEAR, 2'd0, 32'd0, 16'sd0);
        for (int k = 0; k < MAX_PEAKS_DEF + 4; k++) begin
          if (k < MAX_PEAKS_DEF - 1)
            t = base + 1 + $urandom_range(5000);
          else if (k == MAX_PEAKS_DEF - 1)
            t = base - $urandom_range(100);
          else
            t = base;
          send_word(OP_LOAD, ch, t, HEIGHT_W'($urandom));
        end
        for (int c = 0; c < NREF; c++) begin
          if (c != ch)
            send_word(OP_LOAD, CH_W'(c), base - 10, 16'sd0);
        end
        send_word(OP_QUERY, 2'd0, base, HEIGHT_W'($urandom));
        send_word(OP_QUERY, 2'd0, base + 7000, HEIGHT_W'($urandom));
        send_word(OP_QUERY, 2'd0, base - 200, HEIGHT_W'($urandom));
        send_word(OP_CLEAR, 2'd0, 32'd0, 16'sd0);
        send_word(OP_QUERY, 2'd0, base, HEIGHT_W'($urandom));
      end
    end

    // drain and give the verdict
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
